[sv/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the mouse packet to quadrature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

    // Width of each axis's pending-step counter
    localparam int PENDING_BITS = 16;

    // Most pin writes one item can cause
    localparam int MAX_WRITES   = 4;
    localparam int SLOT_BITS    = $clog2(MAX_WRITES);
    localparam int COUNT_BITS   = $clog2(MAX_WRITES + 1);

    // Item kinds
    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Pin codes
    localparam logic [2:0] PIN_XA    = 3'd0;
    localparam logic [2:0] PIN_XB    = 3'd1;
    localparam logic [2:0] PIN_YA    = 3'd2;
    localparam logic [2:0] PIN_YB    = 3'd3;
    localparam logic [2:0] PIN_LEFT  = 3'd4;
    localparam logic [2:0] PIN_RIGHT = 3'd5;

    // Status byte button masks
    localparam logic [7:0] BTN_LEFT_MASK  = 8'h01;
    localparam logic [7:0] BTN_RIGHT_MASK = 8'h02;

    typedef logic [PENDING_BITS-1:0] pending_t;
    typedef logic [COUNT_BITS-1:0]   wr_count_t;
    typedef logic [SLOT_BITS-1:0]    wr_slot_t;

    // Input beat
    typedef struct packed {
        logic              req_type;
        logic [7:0]        status_byte;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
    } req_beat_t;

    // Output beat
    typedef struct packed {
        logic [2:0] pin_id;
        logic       pin_level;
        logic       last_write;
    } wr_beat_t;

    // One pin write held in the result list
    typedef struct packed {
        logic [2:0] pin_id;
        logic       pin_level;
    } pin_write_t;

    // All pin writes caused by one item
    typedef struct packed {
        wr_count_t                       count;
        pin_write_t [MAX_WRITES-1:0]     writes;
    } wr_list_t;

endpackage

`default_nettype wire

[sv/mpq_core.sv]
// ----------------------------------------------------------------------------
// mpq_core
// Mouse state and the single-pass step: turns one item into its pin writes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire mpq_pkg::req_beat_t item,
    output mpq_pkg::wr_list_t      list
);
    import mpq_pkg::*;

    logic     x_level_reg, x_level_next;
    logic     y_level_reg, y_level_next;
    logic     x_neg_reg,   x_neg_next;
    logic     y_neg_reg,   y_neg_next;
    pending_t x_pend_reg,  x_pend_next;
    pending_t y_pend_reg,  y_pend_next;
    logic     left_reg,    left_next;
    logic     right_reg,   right_next;
    logic     parity_reg,  parity_next;

    logic      left_now;
    logic      right_now;
    wr_count_t n;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_level_reg <= 1'b0;
            y_level_reg <= 1'b0;
            x_neg_reg   <= 1'b0;
            y_neg_reg   <= 1'b0;
            x_pend_reg  <= '0;
            y_pend_reg  <= '0;
            left_reg    <= 1'b0;
            right_reg   <= 1'b0;
            parity_reg  <= 1'b0;
        end
        else if (step)
        begin
            x_level_reg <= x_level_next;
            y_level_reg <= y_level_next;
            x_neg_reg   <= x_neg_next;
            y_neg_reg   <= y_neg_next;
            x_pend_reg  <= x_pend_next;
            y_pend_reg  <= y_pend_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            parity_reg  <= parity_next;
        end
    end

    assign left_now  = |(item.status_byte & BTN_LEFT_MASK);
    assign right_now = |(item.status_byte & BTN_RIGHT_MASK);

    // Next state and the list of writes, appended in order
    always_comb
    begin
        x_level_next = x_level_reg;
        y_level_next = y_level_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_pend_next  = x_pend_reg;
        y_pend_next  = y_pend_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        parity_next  = parity_reg;
        n            = '0;
        list.writes  = '0;

        unique case (item.req_type)
            REQ_PACKET:
            begin
                // buttons: active-low pins, written on change only
                if (left_now != left_reg)
                begin
                    list.writes[n[SLOT_BITS-1:0]] = '{pin_id: PIN_LEFT, pin_level: !left_now};
                    n = n + 1'b1;
                    left_next = left_now;
                end
                if (right_now != right_reg)
                begin
                    list.writes[n[SLOT_BITS-1:0]] = '{pin_id: PIN_RIGHT,
                                                     pin_level: !right_now};
                    n = n + 1'b1;
                    right_next = right_now;
                end
                // movement on every second packet, saturating
                if (parity_reg)
                begin
                    if (item.delta_x != '0)
                    begin
                        x_neg_next = item.delta_x[7];
                        if (x_pend_reg != '1)
                            x_pend_next = x_pend_reg + 1'b1;
                    end
                    if (item.delta_y != '0)
                    begin
                        y_neg_next = item.delta_y[7];
                        if (y_pend_reg != '1)
                            y_pend_next = y_pend_reg + 1'b1;
                    end
                end
                parity_next = !parity_reg;
            end
            REQ_TICK:
            begin
                // X axis first
                if (x_pend_reg != '0)
                begin
                    x_level_next = !x_level_reg;
                    if (x_neg_reg)
                    begin
                        list.writes[0] = '{pin_id: PIN_XB, pin_level: x_level_next};
                        list.writes[1] = '{pin_id: PIN_XA, pin_level: x_level_next};
                    end
                    else
                    begin
                        list.writes[0] = '{pin_id: PIN_XA, pin_level: x_level_next};
                        list.writes[1] = '{pin_id: PIN_XB, pin_level: x_level_next};
                    end
                    n = COUNT_BITS'(2);
                    x_pend_next = x_pend_reg - 1'b1;
                end
                // then Y
                if (y_pend_reg != '0)
                begin
                    y_level_next = !y_level_reg;
                    if (y_neg_reg)
                    begin
                        list.writes[n[SLOT_BITS-1:0]] =
                            '{pin_id: PIN_YA, pin_level: y_level_next};
                        list.writes[n[SLOT_BITS-1:0] + 1'b1] =
                            '{pin_id: PIN_YB, pin_level: y_level_next};
                    end
                    else
                    begin
                        list.writes[n[SLOT_BITS-1:0]] =
                            '{pin_id: PIN_YB, pin_level: y_level_next};
                        list.writes[n[SLOT_BITS-1:0] + 1'b1] =
                            '{pin_id: PIN_YA, pin_level: y_level_next};
                    end
                    n = n + COUNT_BITS'(2);
                    y_pend_next = y_pend_reg - 1'b1;
                end
            end
            default:
            begin
                n = '0;
            end
        endcase

        list.count = n;
    end

endmodule

`default_nettype wire

[sv/mpq_serial.sv]
// ----------------------------------------------------------------------------
// mpq_serial
// Result register: holds one item's pin writes and sends them one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_serial
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mpq_pkg::wr_list_t list,
    output logic                   ready,
    output logic                   wr_valid,
    input  wire logic              wr_stall,
    output mpq_pkg::wr_beat_t      wr_beat
);
    import mpq_pkg::*;

    pin_write_t [MAX_WRITES-1:0] writes_reg;
    wr_count_t                   rem_reg, rem_next;
    wr_slot_t                    idx_reg, idx_next;
    logic                        take;

    assign wr_valid = (rem_reg != '0);
    assign take     = wr_valid && !wr_stall;
    // free now, or freed by the final beat going out this cycle
    assign ready    = (rem_reg == '0) || (take && rem_reg == COUNT_BITS'(1));

    // Remaining count and read slot
    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        priority if (load)
        begin
            rem_next = list.count;
            idx_next = '0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 1'b1;
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            writes_reg <= list.writes;
    end

    // Output beat
    always_comb
    begin
        wr_beat.pin_id     = writes_reg[idx_reg].pin_id;
        wr_beat.pin_level  = writes_reg[idx_reg].pin_level;
        wr_beat.last_write = (rem_reg == COUNT_BITS'(1));
    end

endmodule

`default_nettype wire

[sv/mouse_packet_to_quadrature.sv]
// ----------------------------------------------------------------------------
// mouse_packet_to_quadrature
// Turns relative mouse packets and output ticks into quadrature mouse pin
// writes: button pins on change, phase pin pairs on each tick with steps due.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | beat
//  req     | in  | req_valid/stall  | req_type, status_byte, delta_x, delta_y
//  wr      | out | wr_valid/stall   | pin_id, pin_level, last_write
//
//  An item is held in the input register and takes one pass of the step
//  logic, then its 0 to 4 pin writes leave the result register one per
//  cycle while wr_stall is low; the output port sets the item rate.
//  Reset clears all mouse state; no clearing pass is needed.
//  The next item is held in the input register while writes are still
//  going out, so req_stall rises only when both registers are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_packet_to_quadrature
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire mpq_pkg::req_beat_t req_beat,
    output logic                    wr_valid,
    input  wire logic               wr_stall,
    output mpq_pkg::wr_beat_t       wr_beat
);
    import mpq_pkg::*;

    logic      in_full_reg, in_full_next;
    req_beat_t item_reg;
    logic      ser_ready;
    logic      advance;
    logic      req_take;
    wr_list_t  list;

    // Input register control
    assign advance   = in_full_reg && ser_ready;
    assign req_stall = in_full_reg && !ser_ready;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        priority if (req_take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            item_reg <= req_beat;
    end

    // Step logic and mouse state
    mpq_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .list  (list)
    );

    // Result register and write sequencing
    mpq_serial u_serial
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .list     (list),
        .ready    (ser_ready),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr_beat  (wr_beat)
    );

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_full_reg)
        else $error("req_stall raised with an empty input register");

    a_more_writes_follow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_stall && !wr_beat.last_write |=> wr_valid)
        else $error("pin write list ended without a last write");

    a_drain_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_stall && wr_beat.last_write && !in_full_reg |=> !wr_valid)
        else $error("writes appeared with no item pending");

    a_stall_frees_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && wr_valid && !wr_stall && wr_beat.last_write |-> !req_stall)
        else $error("input held back although the result register frees");

endmodule

`default_nettype wire
